FILE: rtl/i2rd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// i2rd_pkg
// Shared types, constants and the digit encoding for the integer to
// radix digits converter.
// ============================================================================
package i2rd_pkg;

    // Width of the value that is converted (8 to 64).
    localparam int VALUE_WIDTH = 32;
    // Width of the number port, fixed by the interface.
    localparam int IN_W        = 32;
    // Bits of the value actually used.
    localparam int USE_W       = (VALUE_WIDTH < IN_W) ? VALUE_WIDTH : IN_W;

    // The divider retires this many quotient bits per cycle.
    localparam int STEP_BITS   = 8;
    localparam int DIV_STEPS   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int SH_W        = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Digit stack: at most one digit per value bit (base two).
    localparam int IDX_W       = $clog2(VALUE_WIDTH);

    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] BASE_MIN    = 5'd2;
    localparam logic [RADIX_W-1:0] BASE_MAX    = 5'd16;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new value
        logic step;   // one division step of STEP_BITS bits
        logic push;   // store the remainder as the next digit
        logic pop;    // move the top digit into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quot_zero;  // the quotient just formed is zero
        logic ptr_zero;   // the digit pointer is at the bottom of the stack
    } t_sts;

    function automatic logic [CHAR_W-1:0] digit_code(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

FILE: rtl/i2rd_dpath.sv
`timescale 1ns / 1ps
// ============================================================================
// i2rd_dpath
// Radix register, multi-cycle divider by the base, digit stack and the
// output payload register.
// ============================================================================
module i2rd_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [i2rd_pkg::RADIX_W-1:0]   i_radix,
    input  logic [i2rd_pkg::IN_W-1:0]      i_number,
    input  i2rd_pkg::t_cmd                 i_cmd,
    output i2rd_pkg::t_sts                 o_sts,
    output logic [i2rd_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                           o_last_digit
);

    logic [i2rd_pkg::RADIX_W-1:0] r_base;
    logic [i2rd_pkg::RADIX_W-1:0] n_base;
    logic [i2rd_pkg::SH_W-1:0]    r_sh;
    logic [i2rd_pkg::SH_W-1:0]    n_sh;
    logic [i2rd_pkg::DIGIT_W-1:0] r_rem;
    logic [i2rd_pkg::DIGIT_W-1:0] n_rem;
    logic [i2rd_pkg::IDX_W-1:0]   r_ptr;
    logic [i2rd_pkg::DIGIT_W-1:0] r_stack [i2rd_pkg::VALUE_WIDTH];
    logic [i2rd_pkg::CHAR_W-1:0]  r_char;
    logic                         r_last;

    // Values outside 2..16 are clamped to the nearest supported base.
    always_comb begin
        if (i_radix < i2rd_pkg::BASE_MIN) begin
            n_base = i2rd_pkg::BASE_MIN;
        end else if (i_radix > i2rd_pkg::BASE_MAX) begin
            n_base = i2rd_pkg::BASE_MAX;
        end else begin
            n_base = i_radix;
        end
    end

    // Restoring division, STEP_BITS bits per cycle. Dividend bits leave at
    // the top of the shift register while quotient bits enter at the bottom,
    // so once the last step is done it holds the quotient.
    always_comb begin
        logic [i2rd_pkg::DIGIT_W:0] t;
        n_sh  = r_sh;
        n_rem = r_rem;
        for (int i = 0; i < i2rd_pkg::STEP_BITS; i++) begin
            t    = {n_rem, n_sh[i2rd_pkg::SH_W-1]};
            n_sh = {n_sh[i2rd_pkg::SH_W-2:0], 1'b0};
            if (t >= r_base) begin
                n_rem   = i2rd_pkg::DIGIT_W'(t - r_base);
                n_sh[0] = 1'b1;
            end else begin
                n_rem = t[i2rd_pkg::DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= i2rd_pkg::RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_base <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sh  <= i2rd_pkg::SH_W'(i_number[i2rd_pkg::USE_W-1:0]);
            r_rem <= '0;
            r_ptr <= '0;
        end
        if (i_cmd.step) begin
            r_sh  <= n_sh;
            r_rem <= n_rem;
        end
        if (i_cmd.push) begin
            r_stack[r_ptr] <= r_rem;
            r_rem          <= '0;
            // The pointer stays on the top digit once the quotient is zero.
            if (r_sh != '0) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
        if (i_cmd.pop) begin
            r_char <= i2rd_pkg::digit_code(r_stack[r_ptr]);
            r_last <= (r_ptr == '0);
            r_ptr  <= r_ptr - 1'b1;
        end
    end

    assign o_sts.quot_zero = (r_sh == '0);
    assign o_sts.ptr_zero  = (r_ptr == '0);
    assign o_digit_char    = r_char;
    assign o_last_digit    = r_last;

endmodule

FILE: rtl/i2rd_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// i2rd_ctrl
// Sequencer for the converter: division rounds, digit pushes and the
// output handshake.
// ============================================================================
module i2rd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  i2rd_pkg::t_sts i_sts,
    output i2rd_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [i2rd_pkg::STEP_CNT_W-1:0] r_step;
    logic                            r_valid;
    logic                            w_pop;

    // A digit may enter the output register when it is empty or being taken.
    assign w_pop   = (r_state == S_EMIT) && (!r_valid || i_ready);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        o_cmd.step = (r_state == S_DIV);
        o_cmd.push = (r_state == S_PUSH);
        o_cmd.pop  = w_pop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_DIV;
                        r_step  <= '0;
                    end
                end
                S_DIV: begin
                    if (r_step == i2rd_pkg::STEP_CNT_W'(i2rd_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_PUSH;
                    end
                    r_step <= r_step + 1'b1;
                end
                S_PUSH: begin
                    r_step <= '0;
                    if (i_sts.quot_zero) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_EMIT: begin
                    if (w_pop && i_sts.ptr_zero) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/integer_to_radix_digits.sv
`timescale 1ns / 1ps
// ============================================================================
// integer_to_radix_digits
// Converts an unsigned value to ASCII digits in a base from 2 to 16,
// most significant digit first, flagging the final digit.
// ============================================================================
//  Channel   Direction  Handshake                 Payload
//  input     in         i_valid / o_ready         i_number
//  output    out        o_valid / i_ready         o_digit_char, o_last_digit
//  config    in         i_cfg_valid / o_cfg_ready i_radix
//
//  Each digit is formed by DIV_STEPS division steps in the divider, eight
//  quotient bits per cycle, and a push onto the digit stack; once the
//  quotient is zero the digits leave the stack, most significant first.
//  One item is in work at a time; the next is taken once the last digit
//  has entered the output register. Output stalls hold the digit sequencer.
//  Reset is synchronous, active low, and sets the base to ten.
// ============================================================================
module integer_to_radix_digits (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [i2rd_pkg::IN_W-1:0]      i_number,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [i2rd_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                           o_last_digit,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [i2rd_pkg::RADIX_W-1:0]   i_radix
);

    i2rd_pkg::t_cmd w_cmd;
    i2rd_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    i2rd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    i2rd_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_radix      (i_radix),
        .i_number     (i_number),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule
